// ===== rtl/limit_order_book_matcher_defines.svh =====
// Assertion macros for the limit order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`ifndef SYNTH
`define LOBM_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define LOBM_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define LOBM_ASSERT_IMP(label, clk, rst_n, a, b)
`define LOBM_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/lobm_pkg.sv =====
// Types, constants and helpers shared by the order book matcher.
`default_nettype none
package lobm_pkg;
	localparam int BOOK_SLOTS = 32;
	localparam int SLOT_W = $clog2(BOOK_SLOTS);
	localparam int CNT_W = $clog2(BOOK_SLOTS + 1);
	localparam int SUM_W = 24 + $clog2(BOOK_SLOTS + 1);

	localparam logic OP_NEW = 1'b0;
	localparam logic OP_CANCEL = 1'b1;
	localparam logic SIDE_BUY = 1'b0;

	localparam logic [1:0] TYPE_LIMIT = 2'd0;
	localparam logic [1:0] TYPE_FOK = 2'd3;

	localparam logic [1:0] KIND_TRADE = 2'd0;
	localparam logic [1:0] KIND_BBO = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_FINISH} state_t;

	typedef struct packed {
		logic side;
		logic [31:0] price;
		logic [23:0] quantity;
		logic [31:0] order_id;
		logic [31:0] arrival;
	} slot_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] buy_order_id;
		logic [31:0] sell_order_id;
		logic [31:0] trade_price;
		logic [23:0] trade_quantity;
		logic [31:0] best_bid;
		logic bid_present;
		logic [31:0] best_ask;
		logic ask_present;
		logic last;
	} result_t;

	typedef struct packed {
		logic [31:0] order_id;
		logic opp;
		logic [31:0] limit;
		logic [31:0] arr_cnt;
	} query_t;

	typedef struct packed {
		logic id_hit;
		logic [SLOT_W-1:0] id_idx;
		logic best_found;
		logic [SLOT_W-1:0] best_idx;
		slot_t best;
		logic [31:0] best_age;
		logic [SUM_W-1:0] avail;
		logic bid_present;
		logic [31:0] best_bid;
		logic ask_present;
		logic [31:0] best_ask;
	} stats_t;

	// resting price on side rs qualifies against incoming limit
	function automatic logic qualifies(logic rs, logic [31:0] rp, logic [31:0] limit);
		logic q;
		if (limit == 32'd0) q = 1'b1;
		else if (rs) q = (rp <= limit);
		else q = (rp >= limit);
		return q;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/lobm_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/lobm_scan.sv =====
// Per-pass accumulators: id lookup, best opposite slot, FOK depth, best bid/offer.
`default_nettype none
module lobm_scan import lobm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clr,
	input wire logic en,
	input wire logic vld,
	input wire logic [SLOT_W-1:0] idx,
	input wire slot_t entry,
	input wire query_t qry,
	output stats_t st
);
	stats_t st_q, st_d;
	logic [31:0] age;
	logic better;

	assign age = qry.arr_cnt - entry.arrival;
	assign st = st_q;

	always_comb begin
		if (!st_q.best_found) better = 1'b1;
		else if (entry.price != st_q.best.price) begin
			better = qry.opp ? (entry.price < st_q.best.price) : (entry.price > st_q.best.price);
		end else better = (age > st_q.best_age);
	end

	always_comb begin
		st_d = st_q;
		if (en && vld) begin
			if (entry.order_id == qry.order_id) begin
				st_d.id_hit = 1'b1;
				st_d.id_idx = idx;
			end
			if (entry.side == qry.opp) begin
				if (better) begin
					st_d.best_found = 1'b1;
					st_d.best_idx = idx;
					st_d.best = entry;
					st_d.best_age = age;
				end
				if (qualifies(qry.opp, entry.price, qry.limit)) begin
					st_d.avail = st_q.avail + SUM_W'(entry.quantity);
				end
			end
			if (entry.side == SIDE_BUY) begin
				st_d.bid_present = 1'b1;
				if (!st_q.bid_present || entry.price > st_q.best_bid) st_d.best_bid = entry.price;
			end else begin
				st_d.ask_present = 1'b1;
				if (!st_q.ask_present || entry.price < st_q.best_ask) st_d.best_ask = entry.price;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (clr) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// Top level: order book sequencer, slot memory and result buffering.
`default_nettype none
`include "limit_order_book_matcher_defines.svh"
// Price-time priority order book over BOOK_SLOTS slots held in one RAM. Every
// input runs one scan pass over all slots (one RAM read a cycle, fed through
// the registered read into the scan accumulators), then one more pass after
// each trade and one for the final best bid/offer, each pass followed by a
// decision state. Output stalls can hold the decision and finish states; a
// cancel takes two passes, a duplicate or unknown id one. One input is worked
// at a time. Results are held one word back so tlast can mark the final word.
module limit_order_book_matcher import lobm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// order_id[31:0], side[32], price[64:33], quantity[88:65], order_type[90:89]
	input wire logic [95:0] s_tdata,
	// op
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// buy_order_id[31:0], sell_order_id[63:32], trade_price[95:64],
	// trade_quantity[119:96], best_bid[151:120], bid_present[152],
	// best_ask[184:153], ask_present[185]
	output logic [191:0] m_tdata,
	// kind
	output logic [1:0] m_tuser,
	output logic m_tlast
);
	state_t state_q, state_d;
	logic op_q, side_q, first_q, bbo_q, ct_q;
	logic [31:0] id_q, price_q, arr_cnt_q;
	logic [23:0] qty_q;
	logic [1:0] type_q;
	logic [CNT_W-1:0] cnt_q;
	logic rd_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [BOOK_SLOTS-1:0] valid_q;
	result_t pend_q, out_q, res;
	logic pend_valid_q, out_valid_q, out_free;

	slot_t rd_entry, wdata;
	logic we;
	logic [SLOT_W-1:0] waddr;
	query_t qry;
	stats_t st;

	logic emit, fin_push, v_clr, v_set, arr_inc, first_d, bbo_d, ct_d, ct;
	logic [SLOT_W-1:0] v_idx;
	logic [23:0] qty_d, tq;
	logic free_found;
	logic [SLOT_W-1:0] free_idx;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign qry = '{order_id: id_q, opp: ~side_q, limit: price_q, arr_cnt: arr_cnt_q};

	lobm_ram #(.WIDTH($bits(slot_t)), .DEPTH(BOOK_SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(cnt_q[SLOT_W-1:0]), .rdata(rd_entry)
	);

	lobm_scan u_scan (
		.clk(clk), .arst_n(arst_n),
		.clr(state_q == ST_SCAN && cnt_q == '0),
		.en(rd_s1), .vld(valid_q[idx_s1]), .idx(idx_s1),
		.entry(rd_entry), .qry(qry), .st(st)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = BOOK_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign tq = (qty_q < st.best.quantity) ? qty_q : st.best.quantity;
	assign ct = first_q ? (type_q != TYPE_FOK || st.avail >= SUM_W'(qty_q)) : ct_q;

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		res = '0;
		we = 1'b0;
		waddr = st.best_idx;
		wdata = st.best;
		v_clr = 1'b0;
		v_set = 1'b0;
		v_idx = st.best_idx;
		arr_inc = 1'b0;
		fin_push = 1'b0;
		qty_d = qty_q;
		first_d = first_q;
		bbo_d = bbo_q;
		ct_d = ct_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					qty_d = s_tdata[88:65];
					first_d = 1'b1;
					bbo_d = 1'b0;
					ct_d = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(BOOK_SLOTS) && !rd_s1) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (bbo_q) begin
					if (st.bid_present || st.ask_present) begin
						if (!pend_valid_q || out_free) begin
							emit = 1'b1;
							res.kind = KIND_BBO;
							res.best_bid = st.bid_present ? st.best_bid : 32'd0;
							res.bid_present = st.bid_present;
							res.best_ask = st.ask_present ? st.best_ask : 32'd0;
							res.ask_present = st.ask_present;
							state_d = ST_FINISH;
						end
					end else state_d = ST_FINISH;
				end else if (first_q && op_q == OP_CANCEL) begin
					if (st.id_hit) begin
						v_clr = 1'b1;
						v_idx = st.id_idx;
						bbo_d = 1'b1;
						state_d = ST_SCAN;
					end else state_d = ST_IDLE;
				end else if (first_q && st.id_hit) begin
					state_d = ST_IDLE;
				end else if (ct && qty_q != 24'd0 && st.best_found &&
						qualifies(~side_q, st.best.price, price_q)) begin
					if (!pend_valid_q || out_free) begin
						first_d = 1'b0;
						ct_d = ct;
						emit = 1'b1;
						res.kind = KIND_TRADE;
						res.buy_order_id = (side_q == SIDE_BUY) ? id_q : st.best.order_id;
						res.sell_order_id = (side_q == SIDE_BUY) ? st.best.order_id : id_q;
						res.trade_price = st.best.price;
						res.trade_quantity = tq;
						we = 1'b1;
						wdata.quantity = st.best.quantity - tq;
						v_clr = (st.best.quantity == tq);
						qty_d = qty_q - tq;
						state_d = ST_SCAN;
					end
				end else if (ct && qty_q != 24'd0 && type_q == TYPE_LIMIT) begin
					if (free_found) begin
						we = 1'b1;
						waddr = free_idx;
						wdata = '{side: side_q, price: price_q, quantity: qty_q,
							order_id: id_q, arrival: arr_cnt_q};
						v_set = 1'b1;
						v_idx = free_idx;
						arr_inc = 1'b1;
						bbo_d = 1'b1;
						state_d = ST_SCAN;
					end else if (!pend_valid_q || out_free) begin
						emit = 1'b1;
						res.kind = KIND_FULL;
						bbo_d = 1'b1;
						state_d = ST_SCAN;
					end
				end else begin
					bbo_d = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_FINISH: begin
				if (!pend_valid_q) state_d = ST_IDLE;
				else if (out_free) begin
					fin_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			arr_cnt_q <= '0;
			cnt_q <= '0;
			rd_s1 <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			first_q <= 1'b0;
			bbo_q <= 1'b0;
			ct_q <= 1'b0;
		end else begin
			if (v_clr) valid_q[v_idx] <= 1'b0;
			if (v_set) valid_q[v_idx] <= 1'b1;
			if (arr_inc) arr_cnt_q <= arr_cnt_q + 32'd1;
			first_q <= first_d;
			bbo_q <= bbo_d;
			ct_q <= ct_d;
			rd_s1 <= 1'b0;
			if (state_q == ST_SCAN) begin
				if (cnt_q != CNT_W'(BOOK_SLOTS)) begin
					cnt_q <= cnt_q + CNT_W'(1);
					rd_s1 <= 1'b1;
				end
			end else begin
				cnt_q <= '0;
			end
			if (fin_push || (emit && pend_valid_q)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (emit) pend_valid_q <= 1'b1;
			else if (fin_push) pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[SLOT_W-1:0];
		qty_q <= qty_d;
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q <= s_tuser;
			id_q <= s_tdata[31:0];
			side_q <= s_tdata[32];
			price_q <= s_tdata[64:33];
			type_q <= s_tdata[90:89];
		end
		// last is the low bit of the word; set only on the final push
		if (fin_push || (emit && pend_valid_q)) begin
			out_q <= result_t'({pend_q[$bits(result_t)-1:1], fin_push});
		end
		if (emit) pend_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.kind;
	assign m_tlast = out_q.last;
	assign m_tdata = {6'd0, out_q.ask_present, out_q.best_ask, out_q.bid_present,
		out_q.best_bid, out_q.trade_quantity, out_q.trade_price,
		out_q.sell_order_id, out_q.buy_order_id};

	`LOBM_ASSERT_IMP(a_idle_no_pending, clk, arst_n, s_tvalid && s_tready, !pend_valid_q)
	`LOBM_ASSERT_NXT(a_out_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`LOBM_ASSERT_NXT(a_accept_scans, clk, arst_n, s_tvalid && s_tready, state_q == ST_SCAN)
endmodule
`default_nettype wire

// ===== verif/tb_limit_order_book_matcher.sv =====
// Testbench for the limit order book matcher: directed table, random orders, scoreboard.
`default_nettype none
module tb_limit_order_book_matcher;
	import lobm_pkg::*;

	localparam logic [1:0] TYPE_MARKET = 2'd1;
	localparam logic [1:0] TYPE_IOC = 2'd2;
	localparam int RAND_ORDERS = 350;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int EXP_W = 12;

	typedef struct packed {
		logic op;
		logic [31:0] order_id;
		logic side;
		logic [31:0] price;
		logic [23:0] quantity;
		logic [1:0] order_type;
	} order_t;

	typedef struct {
		order_t ord;
		int n_results; // -1 when only the predictor decides
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	limit_order_book_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the book
	logic bk_valid [BOOK_SLOTS];
	logic bk_side [BOOK_SLOTS];
	logic [31:0] bk_price [BOOK_SLOTS];
	logic [23:0] bk_qty [BOOK_SLOTS];
	logic [31:0] bk_id [BOOK_SLOTS];
	logic [31:0] bk_arrival [BOOK_SLOTS];
	logic [31:0] arrivals;

	// expected words, ring buffer
	result_t exp_mem [2**EXP_W];
	logic [EXP_W-1:0] exp_wr = '0;
	logic [EXP_W-1:0] exp_rd = '0;
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	function automatic void add_expected(result_t r);
		exp_mem[exp_wr] = r;
		exp_wr = exp_wr + 1'b1;
	endfunction

	function automatic logic price_ok(logic rs, logic [31:0] rp, logic [31:0] lim);
		if (lim == 32'd0) return 1'b1;
		return rs ? (rp <= lim) : (rp >= lim);
	endfunction

	function automatic int find_order(logic [31:0] id);
		for (int i = 0; i < BOOK_SLOTS; i++)
			if (bk_valid[i] && bk_id[i] == id) return i;
		return -1;
	endfunction

	function automatic void push_quote();
		result_t r;
		r = '0;
		r.kind = KIND_BBO;
		for (int i = 0; i < BOOK_SLOTS; i++) begin
			if (!bk_valid[i]) continue;
			if (bk_side[i] == SIDE_BUY) begin
				if (!r.bid_present || bk_price[i] > r.best_bid) r.best_bid = bk_price[i];
				r.bid_present = 1'b1;
			end else begin
				if (!r.ask_present || bk_price[i] < r.best_ask) r.best_ask = bk_price[i];
				r.ask_present = 1'b1;
			end
		end
		if (r.bid_present || r.ask_present) add_expected(r);
	endfunction

	// returns number of results this order produces
	function automatic int match_order(order_t o);
		int best, f;
		logic [EXP_W-1:0] w0;
		logic opp;
		logic [23:0] left, tq;
		logic [31:0] ab, ai;
		logic [SUM_W-1:0] avail;
		logic go;
		result_t r;
		w0 = exp_wr;
		opp = ~o.side;
		left = o.quantity;
		go = 1'b1;
		if (o.op == OP_CANCEL) begin
			f = find_order(o.order_id);
			if (f < 0) return 0;
			bk_valid[f] = 1'b0;
		end else begin
			if (find_order(o.order_id) >= 0) return 0;
			if (o.order_type == TYPE_FOK) begin
				avail = '0;
				for (int i = 0; i < BOOK_SLOTS; i++)
					if (bk_valid[i] && bk_side[i] == opp && price_ok(opp, bk_price[i], o.price))
						avail += SUM_W'(bk_qty[i]);
				go = (avail >= SUM_W'(left));
			end
			while (go && left != 0) begin
				best = -1;
				for (int i = 0; i < BOOK_SLOTS; i++) begin
					if (!bk_valid[i] || bk_side[i] != opp) continue;
					if (best < 0) best = i;
					else if (bk_price[i] != bk_price[best]) begin
						if (opp ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
							best = i;
					end else begin
						ai = arrivals - bk_arrival[i];
						ab = arrivals - bk_arrival[best];
						if (ai > ab) best = i;
					end
				end
				if (best < 0 || !price_ok(opp, bk_price[best], o.price)) break;
				tq = (left < bk_qty[best]) ? left : bk_qty[best];
				r = '0;
				r.kind = KIND_TRADE;
				r.buy_order_id = (o.side == SIDE_BUY) ? o.order_id : bk_id[best];
				r.sell_order_id = (o.side == SIDE_BUY) ? bk_id[best] : o.order_id;
				r.trade_price = bk_price[best];
				r.trade_quantity = tq;
				add_expected(r);
				left -= tq;
				bk_qty[best] -= tq;
				if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
			end
			if (go && left != 0 && o.order_type == TYPE_LIMIT) begin
				f = -1;
				for (int i = 0; i < BOOK_SLOTS; i++)
					if (!bk_valid[i]) begin
						f = i;
						break;
					end
				if (f < 0) begin
					r = '0;
					r.kind = KIND_FULL;
					add_expected(r);
				end else begin
					bk_valid[f] = 1'b1;
					bk_side[f] = o.side;
					bk_price[f] = o.price;
					bk_qty[f] = left;
					bk_id[f] = o.order_id;
					bk_arrival[f] = arrivals;
					arrivals++;
				end
			end
		end
		push_quote();
		if (exp_wr != w0) exp_mem[exp_wr - 1'b1].last = 1'b1;
		return int'(exp_wr - w0);
	endfunction

	function automatic order_t mk(logic op, logic [31:0] id, logic sd, logic [31:0] px,
		logic [23:0] q, logic [1:0] ty);
		order_t o;
		o.op = op;
		o.order_id = id;
		o.side = sd;
		o.price = px;
		o.quantity = q;
		o.order_type = ty;
		return o;
	endfunction

	function automatic order_t random_order();
		order_t o;
		int pick;
		o.op = ($urandom_range(0, 99) < 10) ? OP_CANCEL : OP_NEW;
		o.order_id = ($urandom_range(0, 99) < 5) ? $urandom : $urandom_range(1, 48);
		o.side = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 85) o.price = (o.side == SIDE_BUY) ? $urandom_range(990, 1005)
			: $urandom_range(1000, 1015);
		else if (pick < 90) o.price = 32'd0;
		else if (pick < 95) o.price = $urandom;
		else o.price = 32'hFFFF_FFFF;
		pick = $urandom_range(0, 99);
		if (pick < 80) o.quantity = 24'($urandom_range(1, 50));
		else if (pick < 85) o.quantity = 24'd0;
		else if (pick < 95) o.quantity = 24'($urandom);
		else o.quantity = 24'hFF_FFFF;
		pick = $urandom_range(0, 99);
		if (pick < 55) o.order_type = TYPE_LIMIT;
		else if (pick < 70) o.order_type = TYPE_MARKET;
		else if (pick < 85) o.order_type = TYPE_IOC;
		else o.order_type = TYPE_FOK;
		return o;
	endfunction

	// one word per call; waits through random gaps and backpressure
	task automatic send_order(order_t o, int n_results);
		int got;
		if (!calm) begin
			while ($urandom_range(0, 99) < 17) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= o.op;
		s_tdata <= {5'd0, o.order_type, o.quantity, o.price, o.side, o.order_id};
		do @(posedge clk); while (!s_tready);
		got = match_order(o);
		if (n_results >= 0 && got != n_results) begin
			$error("result count: expected %0d actual %0d", n_results, got);
			errors++;
		end
	endtask

	row_t plan [] = '{
		'{mk(OP_CANCEL, 32'd5, 1'b0, 32'd0, 24'd0, TYPE_LIMIT), 0},
		'{mk(OP_NEW, 32'd1, 1'b0, 32'd100, 24'd10, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd1, 1'b1, 32'd90, 24'd3, TYPE_LIMIT), 0},
		'{mk(OP_NEW, 32'd2, 1'b1, 32'd110, 24'd5, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd3, 1'b1, 32'd100, 24'd4, TYPE_LIMIT), 2},
		'{mk(OP_NEW, 32'd4, 1'b1, 32'd0, 24'd20, TYPE_MARKET), 2},
		'{mk(OP_NEW, 32'd5, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF, TYPE_LIMIT), 2},
		'{mk(OP_NEW, 32'd6, 1'b0, 32'd50, 24'd0, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd7, 1'b1, 32'd0, 24'hFF_FFFF, TYPE_FOK), 1},
		'{mk(OP_NEW, 32'd8, 1'b1, 32'd0, 24'd100, TYPE_FOK), 2},
		'{mk(OP_NEW, 32'd9, 1'b1, 32'hFFFF_FFFF, 24'd3, TYPE_IOC), 2},
		'{mk(OP_CANCEL, 32'd5, 1'b0, 32'd0, 24'd0, TYPE_LIMIT), 0},
		'{mk(OP_NEW, 32'd0, 1'b1, 32'd1, 24'd1, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'hFFFF_FFFF, 1'b1, 32'd1, 24'd2, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd10, 1'b0, 32'd1, 24'd3, TYPE_IOC), -1},
		'{mk(OP_NEW, 32'd11, 1'b0, 32'd7, 24'd4, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd12, 1'b0, 32'd7, 24'd4, TYPE_LIMIT), 1},
		'{mk(OP_NEW, 32'd13, 1'b1, 32'd7, 24'd5, TYPE_FOK), -1},
		'{mk(OP_NEW, 32'd14, 1'b1, 32'd8, 24'd5, TYPE_FOK), 1},
		'{mk(OP_NEW, 32'd15, 1'b1, 32'd0, 24'd9, TYPE_IOC), -1},
		'{mk(OP_CANCEL, 32'd99, 1'b1, 32'd0, 24'd0, TYPE_LIMIT), 0}
	};

	// fill the book past its slot count, then random traffic
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) send_order(plan[i].ord, plan[i].n_results);
		for (int i = 0; i < BOOK_SLOTS + 3; i++)
			send_order(mk(OP_NEW, 32'h1000 + i, 1'b0, 32'd500 + i, 24'd1, TYPE_LIMIT), -1);
		send_order(mk(OP_NEW, 32'h2000, 1'b1, 32'd0, 24'hFF_FFFF, TYPE_MARKET), -1);
		for (int i = 0; i < RAND_ORDERS; i++) begin
			calm = (i >= 150 && i < 230);
			send_order(random_order(), -1);
		end
		s_tvalid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// output side: check each word, then pick next ready
	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$error("unexpected word: kind %0d", m_tuser);
				errors++;
			end else begin
				want = exp_mem[exp_rd];
				exp_rd <= exp_rd + 1'b1;
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata[31:0] !== want.buy_order_id) begin
					$error("buy_order_id: expected %0h actual %0h", want.buy_order_id,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== want.sell_order_id) begin
					$error("sell_order_id: expected %0h actual %0h", want.sell_order_id,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== want.trade_price) begin
					$error("trade_price: expected %0d actual %0d", want.trade_price,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tdata[119:96] !== want.trade_quantity) begin
					$error("trade_quantity: expected %0d actual %0d", want.trade_quantity,
						m_tdata[119:96]);
					errors++;
				end
				if (m_tdata[151:120] !== want.best_bid) begin
					$error("best_bid: expected %0d actual %0d", want.best_bid,
						m_tdata[151:120]);
					errors++;
				end
				if (m_tdata[152] !== want.bid_present) begin
					$error("bid_present: expected %0d actual %0d", want.bid_present,
						m_tdata[152]);
					errors++;
				end
				if (m_tdata[184:153] !== want.best_ask) begin
					$error("best_ask: expected %0d actual %0d", want.best_ask,
						m_tdata[184:153]);
					errors++;
				end
				if (m_tdata[185] !== want.ask_present) begin
					$error("ask_present: expected %0d actual %0d", want.ask_present,
						m_tdata[185]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
		m_tready <= calm || ($urandom_range(0, 99) >= 17);
	end

	initial begin
		for (int i = 0; i < BOOK_SLOTS; i++) begin
			bk_valid[i] = 1'b0;
			bk_side[i] = 1'b0;
			bk_price[i] = '0;
			bk_qty[i] = '0;
			bk_id[i] = '0;
			bk_arrival[i] = '0;
		end
		arrivals = '0;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lobm_pkg.sv
rtl/lobm_ram.sv
rtl/lobm_scan.sv
rtl/limit_order_book_matcher.sv
verif/tb_limit_order_book_matcher.sv
